// ===== hw/rtl/ptfd_pkg.sv =====
// shared types and constants for the tustin pid controller
// register indexes, configuration bundle, pipeline load strobes
// no dependencies
package ptfd_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int DATA_W    = 32;
	localparam int INTEG_W   = 48;
	localparam int SUM_W     = 33;   // error sum or difference
	localparam int TERM_W    = 41;   // 33 x 32 product after the q24 shift
	localparam int PTERM_W   = 40;   // 32 x 32 product after the q24 shift
	localparam int Y_W       = 50;   // unclamped output sum
	localparam int FRAC_SH   = 24;   // gains are q8.24

	localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_I_GAIN  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_D_GAIN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_D_POLE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd5;

	localparam logic [DATA_W-1:0] OUT_MAX_RST = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] OUT_MIN_RST = 32'h8000_0000;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] i_gain;
		logic signed [DATA_W-1:0] d_gain;
		logic signed [DATA_W-1:0] d_pole;
		logic signed [DATA_W-1:0] out_max;
		logic signed [DATA_W-1:0] out_min;
	} cfg_t;

	// load strobe for each pipeline register
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic so;
	} pipe_ld_t;

endpackage

// ===== hw/rtl/ptfd_cfg_regs.sv =====
// configuration register file for the tustin pid controller
// depends on ptfd_pkg
module ptfd_cfg_regs import ptfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [DATA_W-1:0]    wr_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp      <= '0;
			cfg_q.i_gain  <= '0;
			cfg_q.d_gain  <= '0;
			cfg_q.d_pole  <= '0;
			cfg_q.out_max <= OUT_MAX_RST;
			cfg_q.out_min <= OUT_MIN_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_KP:      cfg_q.kp      <= wr_data;
				REG_I_GAIN:  cfg_q.i_gain  <= wr_data;
				REG_D_GAIN:  cfg_q.d_gain  <= wr_data;
				REG_D_POLE:  cfg_q.d_pole  <= wr_data;
				REG_OUT_MAX: cfg_q.out_max <= wr_data;
				REG_OUT_MIN: cfg_q.out_min <= wr_data;
				default: ;   // unknown index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/ptfd_err_mul.sv =====
// input register, saturated error and the three feed-forward gain products
// depends on ptfd_pkg
module ptfd_err_mul import ptfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pipe_ld_t                   ld,
	input  cfg_t                       cfg,
	input  logic [DATA_W-1:0]          setpoint,
	input  logic [DATA_W-1:0]          measured,
	output logic signed [TERM_W-1:0]   ip_s3,
	output logic signed [TERM_W-1:0]   dp_s3,
	output logic signed [PTERM_W-1:0]  pp_s3
);

	logic signed [DATA_W-1:0] sp_s1, ms_s1;
	logic signed [DATA_W-1:0] e_s2, ep_s2;
	logic signed [DATA_W-1:0] e_q;          // error of the previous item
	logic signed [DATA_W:0]   diff;
	logic signed [DATA_W-1:0] e_sat;
	logic signed [SUM_W-1:0]  esum, edif;
	logic signed [2*DATA_W:0] ip_full, dp_full;
	logic signed [2*DATA_W-1:0] pp_full;

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			sp_s1 <= setpoint;
			ms_s1 <= measured;
		end
	end

	assign diff  = {sp_s1[DATA_W-1], sp_s1} - {ms_s1[DATA_W-1], ms_s1};
	assign e_sat = (diff[DATA_W] != diff[DATA_W-1]) ?
		(diff[DATA_W] ? OUT_MIN_RST : OUT_MAX_RST) : diff[DATA_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			e_q <= '0;
		else if (ld.s2)
			e_q <= e_sat;
	end

	always_ff @(posedge clk) begin
		if (ld.s2) begin
			e_s2  <= e_sat;
			ep_s2 <= e_q;
		end
	end

	assign esum = {e_s2[DATA_W-1], e_s2} + {ep_s2[DATA_W-1], ep_s2};
	assign edif = {e_s2[DATA_W-1], e_s2} - {ep_s2[DATA_W-1], ep_s2};

	assign ip_full = (2*DATA_W+1)'(esum) * (2*DATA_W+1)'($signed(cfg.i_gain));
	assign dp_full = (2*DATA_W+1)'(edif) * (2*DATA_W+1)'($signed(cfg.d_gain));
	assign pp_full = (2*DATA_W)'(e_s2) * (2*DATA_W)'($signed(cfg.kp));

	// arithmetic shift by 24 on the exact product is floor division
	always_ff @(posedge clk) begin
		if (ld.s3) begin
			ip_s3 <= ip_full[2*DATA_W:FRAC_SH];
			dp_s3 <= dp_full[2*DATA_W:FRAC_SH];
			pp_s3 <= pp_full[2*DATA_W-1:FRAC_SH];
		end
	end

endmodule

// ===== hw/rtl/ptfd_accum.sv =====
// integrator and filtered derivative state, updated once per item
// depends on ptfd_pkg
module ptfd_accum import ptfd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pipe_ld_t                   ld,
	input  cfg_t                       cfg,
	input  logic signed [TERM_W-1:0]   ip_s3,
	input  logic signed [TERM_W-1:0]   dp_s3,
	input  logic signed [PTERM_W-1:0]  pp_s3,
	output logic signed [INTEG_W-1:0]  integ_s4,
	output logic signed [DATA_W-1:0]   deriv_s4,
	output logic signed [PTERM_W-1:0]  pp_s4
);

	logic signed [INTEG_W-1:0]  integ_q;
	logic signed [DATA_W-1:0]   deriv_q;
	logic signed [2*DATA_W-1:0] pd_full;
	logic signed [TERM_W:0]     dsum;
	logic signed [INTEG_W:0]    isum;
	logic signed [DATA_W-1:0]   deriv_nxt;
	logic signed [INTEG_W-1:0]  integ_nxt;

	assign pd_full = (2*DATA_W)'(deriv_q) * (2*DATA_W)'($signed(cfg.d_pole));
	assign dsum    = (TERM_W+1)'(dp_s3) + (TERM_W+1)'($signed(pd_full[2*DATA_W-1:FRAC_SH]));
	assign isum    = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(ip_s3);

	always_comb begin
		if (dsum > (TERM_W+1)'($signed(OUT_MAX_RST)))
			deriv_nxt = OUT_MAX_RST;
		else if (dsum < (TERM_W+1)'($signed(OUT_MIN_RST)))
			deriv_nxt = OUT_MIN_RST;
		else
			deriv_nxt = dsum[DATA_W-1:0];
	end

	always_comb begin
		if (isum[INTEG_W] != isum[INTEG_W-1])
			integ_nxt = isum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
				: {1'b0, {(INTEG_W-1){1'b1}}};
		else
			integ_nxt = isum[INTEG_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			deriv_q <= '0;
		end else if (ld.s4) begin
			integ_q <= integ_nxt;
			deriv_q <= deriv_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			integ_s4 <= integ_nxt;
			deriv_s4 <= deriv_nxt;
			pp_s4    <= pp_s3;
		end
	end

endmodule

// ===== hw/rtl/ptfd_out.sv =====
// output sum, clamp to the configured limits and result register
// depends on ptfd_pkg
module ptfd_out import ptfd_pkg::*; (
	input  logic                       clk,
	input  pipe_ld_t                   ld,
	input  cfg_t                       cfg,
	input  logic signed [INTEG_W-1:0]  integ_s4,
	input  logic signed [DATA_W-1:0]   deriv_s4,
	input  logic signed [PTERM_W-1:0]  pp_s4,
	output logic [DATA_W-1:0]          drive,
	output logic                       clamped
);

	logic signed [Y_W-1:0] y_s5;
	logic signed [Y_W-1:0] lim_hi, lim_lo;
	logic [DATA_W-1:0]     drive_q;
	logic                  clamped_q;

	always_ff @(posedge clk) begin
		if (ld.s5)
			y_s5 <= Y_W'(pp_s4) + Y_W'(integ_s4) + Y_W'(deriv_s4);
	end

	assign lim_hi = Y_W'($signed(cfg.out_max));
	assign lim_lo = Y_W'($signed(cfg.out_min));

	// upper limit wins when the limits are crossed
	always_ff @(posedge clk) begin
		if (ld.so) begin
			if (y_s5 > lim_hi) begin
				drive_q   <= cfg.out_max;
				clamped_q <= 1'b1;
			end else if (y_s5 < lim_lo) begin
				drive_q   <= cfg.out_min;
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= y_s5[DATA_W-1:0];
				clamped_q <= 1'b0;
			end
		end
	end

	assign drive   = drive_q;
	assign clamped = clamped_q;

endmodule

// ===== hw/rtl/pid_tustin_filtered_derivative.sv =====
// top level of the tustin pid controller with filtered derivative
// depends on ptfd_pkg, ptfd_cfg_regs, ptfd_err_mul, ptfd_accum, ptfd_out
//
// usage
//  - s_axis carries one sample item: setpoint and measured, both q16.16
//  - m_axis returns one result item per sample: the clamped drive and a
//    clamped flag in tuser
//  - cfg_* writes the gain and limit registers; cfg_ready is always high,
//    writes are meant for times when no item is in flight
//  - six registers from input to output: input, error, products,
//    state, sum and output; the pipeline takes a new item every cycle
//    unless a receiver stall has filled it back to the input
//  - the rate is set by the filter loop: d_pole times the stored
//    derivative, add and saturate all sit ahead of the state register,
//    so one item per cycle is sustained while the receiver does not stall
//  - when the receiver stalls, the result stays in the output register
//    and items keep entering until every stage is full; only then does
//    s_axis_tready drop
//  - reset clears every valid bit, the integrator, the derivative state
//    and the previous error, and loads the register reset values
module pid_tustin_filtered_derivative import ptfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,   // [31:0] setpoint, [63:32] measured
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // [31:0] drive
	output logic [0:0]           m_axis_tuser,   // [0] clamped
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	cfg_t     cfg;
	pipe_ld_t ld;

	// stage valid bits, one per pipeline register, plus the output register
	logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
	// a stage can load when it is empty or its content moves on
	logic r1, r2, r3, r4, r5, ro;

	logic signed [TERM_W-1:0]  ip_s3, dp_s3;
	logic signed [PTERM_W-1:0] pp_s3, pp_s4;
	logic signed [INTEG_W-1:0] integ_s4;
	logic signed [DATA_W-1:0]  deriv_s4;
	logic [DATA_W-1:0]         drive;
	logic                      clamped;

	assign ro = !vo_q || m_axis_tready;
	assign r5 = !v5_q || ro;
	assign r4 = !v4_q || r5;
	assign r3 = !v3_q || r4;
	assign r2 = !v2_q || r3;
	assign r1 = !v1_q || r2;

	assign ld.s1 = s_axis_tvalid && r1;
	assign ld.s2 = v1_q && r2;
	assign ld.s3 = v2_q && r3;
	assign ld.s4 = v3_q && r4;
	assign ld.s5 = v4_q && r5;
	assign ld.so = v5_q && ro;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			v1_q <= ld.s1 || (v1_q && !ld.s2);
			v2_q <= ld.s2 || (v2_q && !ld.s3);
			v3_q <= ld.s3 || (v3_q && !ld.s4);
			v4_q <= ld.s4 || (v4_q && !ld.s5);
			v5_q <= ld.s5 || (v5_q && !ld.so);
			vo_q <= ld.so || (vo_q && !m_axis_tready);
		end
	end

	ptfd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// error and gain products
	ptfd_err_mul u_err_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.cfg      (cfg),
		.setpoint (s_axis_tdata[31:0]),
		.measured (s_axis_tdata[63:32]),
		.ip_s3    (ip_s3),
		.dp_s3    (dp_s3),
		.pp_s3    (pp_s3)
	);

	// integrator and derivative filter state
	ptfd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (ld),
		.cfg      (cfg),
		.ip_s3    (ip_s3),
		.dp_s3    (dp_s3),
		.pp_s3    (pp_s3),
		.integ_s4 (integ_s4),
		.deriv_s4 (deriv_s4),
		.pp_s4    (pp_s4)
	);

	// sum, clamp and result register
	ptfd_out u_out (
		.clk      (clk),
		.ld       (ld),
		.cfg      (cfg),
		.integ_s4 (integ_s4),
		.deriv_s4 (deriv_s4),
		.pp_s4    (pp_s4),
		.drive    (drive),
		.clamped  (clamped)
	);

	assign s_axis_tready   = r1;
	assign m_axis_tvalid   = vo_q;
	assign m_axis_tdata    = drive;
	assign m_axis_tuser[0] = clamped;
	assign cfg_ready       = 1'b1;

endmodule

// ===== hw/rtl/ptfd_checker.sv =====
// port-level checks for the tustin pid controller, bound to the top level
// depends on pid_tustin_filtered_derivative
module ptfd_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [31:0]          m_axis_tdata,
	input logic [0:0]           m_axis_tuser,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// input back-pressure only comes from a stalled output
	a_ready_drop: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output back-pressure");

	// an input accepted with the output free shows up while the receiver stays ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid ##1 m_axis_tready
			##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
			##1 m_axis_tready |=> m_axis_tvalid)
		else $error("result missing after six cycles");

	// reset empties the output
	a_reset: assert property (@(posedge clk) !arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// configuration port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind pid_tustin_filtered_derivative ptfd_checker u_ptfd_checker (.*);

// ===== bench/ptfd_drive_checker.sv =====
`timescale 1ns / 1ps
// checker for the tustin pid controller: watches sample, result and register channels
// predicts drive and clamp flag per sample and compares in order; depends on ptfd_pkg
module ptfd_drive_checker import ptfd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [63:0]          s_axis_tdata,   // [31:0] setpoint, [63:32] measured
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [31:0]          m_axis_tdata,   // [31:0] drive
	input  logic [0:0]           m_axis_tuser,   // [0] clamped
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   results,
	output int                   clamp_hits
);

	localparam longint I32_HI   = 64'sd2147483647;
	localparam longint I32_LO   = -64'sd2147483648;
	localparam longint INTEG_HI = 64'sd140737488355327;
	localparam longint INTEG_LO = -64'sd140737488355328;

	typedef struct packed {
		logic [31:0] drive;
		logic        clamped;
	} drive_res_t;

	cfg_t       gains;
	longint     err_prev, integ, deriv;
	drive_res_t drive_owed[$];
	drive_res_t want;
	int         n_bad, n_res, n_clamp;

	// q8.24 gain times value, floored shift by 24
	function automatic longint q24_mul(input logic signed [31:0] g, input longint v);
		logic signed [95:0] prod;
		prod = g * v;
		return longint'(prod >>> FRAC_SH);
	endfunction

	function automatic longint clip(input longint x, input longint lo, input longint hi);
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	// one controller step; advances the predicted state
	function automatic drive_res_t predict_drive(input logic signed [31:0] sp,
			input logic signed [31:0] meas);
		longint     e, d, y;
		drive_res_t r;
		e     = clip(longint'(sp) - longint'(meas), I32_LO, I32_HI);
		integ = clip(integ + q24_mul(gains.i_gain, e + err_prev), INTEG_LO, INTEG_HI);
		d     = q24_mul(gains.d_gain, e - err_prev) + q24_mul(gains.d_pole, deriv);
		deriv = clip(d, I32_LO, I32_HI);
		y     = q24_mul(gains.kp, e) + integ + deriv;
		r.clamped = 1'b0;
		// upper limit has priority when the limits are crossed
		if (y > longint'($signed(gains.out_max))) begin
			y = longint'($signed(gains.out_max));
			r.clamped = 1'b1;
		end else if (y < longint'($signed(gains.out_min))) begin
			y = longint'($signed(gains.out_min));
			r.clamped = 1'b1;
		end
		err_prev = e;
		r.drive  = y[31:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains         = '0;
			gains.out_max = OUT_MAX_RST;
			gains.out_min = OUT_MIN_RST;
			err_prev      = 0;
			integ         = 0;
			deriv         = 0;
			n_bad         = 0;
			n_res         = 0;
			n_clamp       = 0;
			drive_owed.delete();
			mismatches <= 0;
			pending    <= 0;
			results    <= 0;
			clamp_hits <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KP:      gains.kp      = cfg_data;
					REG_I_GAIN:  gains.i_gain  = cfg_data;
					REG_D_GAIN:  gains.d_gain  = cfg_data;
					REG_D_POLE:  gains.d_pole  = cfg_data;
					REG_OUT_MAX: gains.out_max = cfg_data;
					REG_OUT_MIN: gains.out_min = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				drive_owed.push_back(predict_drive(s_axis_tdata[31:0], s_axis_tdata[63:32]));
			if (m_axis_tvalid && m_axis_tready) begin
				if (drive_owed.size() == 0) begin
					if (n_bad < 10)
						$display("%0t: result %h/%0d arrived with nothing outstanding",
							$time, m_axis_tdata, m_axis_tuser[0]);
					n_bad++;
				end else begin
					want = drive_owed.pop_front();
					if (want.drive !== m_axis_tdata || want.clamped !== m_axis_tuser[0]) begin
						if (n_bad < 10)
							$display("%0t: result %0d: drive exp %h got %h, clamped exp %0d got %0d",
								$time, n_res, want.drive, m_axis_tdata, want.clamped,
								m_axis_tuser[0]);
						n_bad++;
					end
				end
				if (m_axis_tuser[0] === 1'b1)
					n_clamp++;
				n_res++;
			end
			mismatches <= n_bad;
			pending    <= drive_owed.size();
			results    <= n_res;
			clamp_hits <= n_clamp;
		end
	end

endmodule

// ===== bench/pid_tustin_filtered_derivative_tb.sv =====
`timescale 1ns / 1ps
// top of the bench for the tustin pid controller: clock, reset, stimulus and verdict
// depends on ptfd_pkg, pid_tustin_filtered_derivative and ptfd_drive_checker
module pid_tustin_filtered_derivative_tb;
	import ptfd_pkg::*;

	// indexes outside the register map, writes to them must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [63:0]          s_axis_tdata;   // [31:0] setpoint, [63:32] measured
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [31:0]          m_axis_tdata;   // [31:0] drive
	logic [0:0]           m_axis_tuser;   // [0] clamped
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0]    cfg_data;

	int mismatches, pending, results, clamp_hits;

	// idle percentages per side and the receiver hold-off counter
	int src_idle   = 0;
	int sink_idle  = 0;
	int stall_left = 0;

	int n_sent = 0;
	int n_cfg  = 0;

	pid_tustin_filtered_derivative i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ptfd_drive_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending),
		.results       (results),
		.clamp_hits    (clamp_hits)
	);

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5ms;
		$display("timeout: %0d samples sent, %0d results still outstanding", n_sent, pending);
		$display("TB_ERROR");
		$finish;
	end

	// receiver: a hold-off request wins over the random idling
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// ---------------------------------------------------------------
	// sample and register drivers, all changes on the falling edge
	// ---------------------------------------------------------------

	// offer one item, with random idle cycles ahead of it; valid stays high on return
	task automatic send_sample(input logic [31:0] sp, input logic [31:0] meas);
		forever begin
			@(negedge clk);
			if ($urandom_range(99) >= src_idle)
				break;
			s_axis_tvalid = 1'b0;
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {meas, sp};
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		n_cfg++;
	endtask

	task automatic load_gains(input logic [31:0] kp, input logic [31:0] ig,
			input logic [31:0] dg, input logic [31:0] dp,
			input logic [31:0] omax, input logic [31:0] omin);
		write_reg(REG_KP, kp);
		write_reg(REG_I_GAIN, ig);
		write_reg(REG_D_GAIN, dg);
		write_reg(REG_D_POLE, dp);
		write_reg(REG_OUT_MAX, omax);
		write_reg(REG_OUT_MIN, omin);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		wait (pending == 0);
	endtask

	// drained plus the pipeline depth, so registers can be touched safely
	task automatic settle();
		drain();
		repeat (10) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// random values
	// ---------------------------------------------------------------

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(4))
			0, 1: return $urandom;
			2: return 32'($urandom_range(2097151)) - 32'd1048576;   // within +-16.0
			3: return 32'($urandom_range(131071)) - 32'd65536;      // within +-1.0
			default: begin
				case ($urandom_range(4))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'hffff_ffff;
					3: return 32'h0000_0001;
					default: return 32'h0;
				endcase
			end
		endcase
	endfunction

	// mostly modest gains within +-2.0, sometimes full range or an extreme
	function automatic logic [31:0] pick_gain();
		case ($urandom_range(7))
			0: return $urandom;
			1: begin
				case ($urandom_range(2))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					default: return 32'h0;
				endcase
			end
			default: return 32'($urandom_range(67108863)) - 32'd33554432;
		endcase
	endfunction

	task automatic load_random_gains();
		logic [31:0] lim, a, b;
		lim = 32'($urandom_range(32'h1000_0000, 32'h0001_0000));
		a   = $urandom;
		b   = $urandom;
		case ($urandom_range(3))
			// full range, clamp only through the limits of the sum
			0: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(),
				OUT_MAX_RST, OUT_MIN_RST);
			1: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), lim, -lim);
			// crossed limits
			2: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), -lim, lim);
			default: load_gains(pick_gain(), pick_gain(), pick_gain(), pick_gain(), a, b);
		endcase
	endtask

	// push_dir 0 gives free samples; +1 or -1 drives a large error of that sign
	// so the integrator winds into its limit, with the odd random sample between
	task automatic sample_batch(input int count, input int push_dir);
		logic [31:0] sp, meas, tmp;
		for (int k = 0; k < count; k++) begin
			if (push_dir == 0 || $urandom_range(31) == 0) begin
				sp = pick_sample();
				if ($urandom_range(3) == 0)
					meas = sp + 32'($urandom_range(8191)) - 32'd4096;
				else
					meas = pick_sample();
			end else begin
				// setpoint at least 2^30, measured at most -2^30: error saturates
				sp   = {2'b01, 30'($urandom)};
				meas = {2'b10, 30'($urandom)};
				if (push_dir < 0) begin
					tmp  = sp;
					sp   = meas;
					meas = tmp;
				end
			end
			send_sample(sp, meas);
		end
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int dir;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_KP;
		cfg_data      = '0;
		arst_n        = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: register reset values, all gains zero, so drive stays zero
		send_sample(32'h7fff_ffff, 32'h8000_0000);
		send_sample(32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h0, 32'h0);
		settle();

		// unit proportional gain, +-1.0 limits, no derivative gain but a pole of 0.5
		load_gains(32'h0100_0000, 32'h0, 32'h0, 32'h0080_0000, 32'h0001_0000, 32'hffff_0000);
		// spare indexes must not disturb any register
		write_reg(REG_SPARE_A, 32'hffff_ffff);
		write_reg(REG_SPARE_B, 32'h5a5a_5a5a);
		send_sample(32'h0001_0000, 32'h0);            // lands exactly on out_max, not clamped
		send_sample(32'h0, 32'h0001_0000);            // lands exactly on out_min, not clamped
		send_sample(32'h0001_0001, 32'h0);            // one lsb above out_max
		send_sample(32'h8000_0000, 32'h7fff_ffff);    // far below out_min
		settle();

		// crossed limits: upper test first, then lower
		write_reg(REG_OUT_MAX, 32'hffff_0000);
		write_reg(REG_OUT_MIN, 32'h0001_0000);
		send_sample(32'h0002_0000, 32'h0);
		send_sample(32'h0, 32'h0002_0000);
		send_sample(32'h0, 32'h0);
		settle();

		// extreme gains and extreme samples: error and derivative saturation
		load_gains(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			OUT_MAX_RST, OUT_MIN_RST);
		send_sample(32'h7fff_ffff, 32'h8000_0000);
		send_sample(32'h8000_0000, 32'h7fff_ffff);
		send_sample(32'h0, 32'h0);
		send_sample(32'h7fff_ffff, 32'h7fff_ffff);
		send_sample(32'h8000_0000, 32'h8000_0000);
		send_sample(32'hffff_ffff, 32'h0000_0001);
		send_sample(32'h0000_0001, 32'hffff_ffff);
		for (int k = 0; k < 4; k++)
			send_sample($urandom, $urandom);
		settle();

		// first idling mode: sender idles lightly, receiver heavily
		src_idle  = 14;
		sink_idle = 55;

		// integrator windup at maximum integral gain, direction picked per run;
		// the sender pauses halfway until every result is back
		dir = $urandom_range(1) ? 1 : -1;
		load_gains(pick_gain(), 32'h7fff_ffff, pick_gain(), pick_gain(),
			OUT_MAX_RST, OUT_MIN_RST);
		sample_batch(150, dir);
		drain();
		sample_batch(130, dir);
		sample_batch(30, -dir);
		settle();

		for (int c = 0; c < 2; c++) begin
			load_random_gains();
			// long receiver hold-off while items keep coming, fills the pipeline
			if (c == 0)
				stall_left = 150;
			sample_batch(35, 0);
			settle();
		end

		// second idling mode: the other way round
		src_idle  = 55;
		sink_idle = 14;
		load_gains(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
			32'h7fff_ffff, 32'h8000_0000);
		sample_batch(30, 0);
		settle();
		for (int c = 0; c < 2; c++) begin
			load_random_gains();
			sample_batch(30, 0);
			settle();
		end

		// back to back on both sides
		src_idle  = 0;
		sink_idle = 0;
		for (int c = 0; c < 2; c++) begin
			load_random_gains();
			sample_batch(20, 0);
			settle();
		end

		drain();
		repeat (20) @(posedge clk);

		$display("run covered %0d samples and %0d register writes, including windup,",
			n_sent, n_cfg);
		$display("crossed limits and receiver hold-off; %0d results checked, %0d clamped",
			results, clamp_hits);
		if (mismatches == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d results outstanding", mismatches, pending);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
